/* design/hba_pkg.sv */
`default_nettype none

package hba_pkg;

    // handle space and field widths
    localparam int HANDLE_SPACE = 65536;
    localparam int HANDLE_W     = 16;
    localparam int BASE_W       = 17;

    // command codes carried in the input tuser
    localparam logic [1:0] MODE_RESERVE       = 2'd0;
    localparam logic [1:0] MODE_FREE          = 2'd1;
    localparam logic [1:0] MODE_LOOKUP_HANDLE = 2'd2;
    localparam logic [1:0] MODE_LOOKUP_DEVICE = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_COUNT     = 2'd2;

    // owner kinds for handle lookup
    localparam logic [1:0] KIND_UNOWNED = 2'd0;
    localparam logic [1:0] KIND_SYSTEM  = 2'd1;
    localparam logic [1:0] KIND_DEVICE  = 2'd2;

    // one entry of the block table
    typedef struct packed {
        logic                in_use;
        logic [HANDLE_W-1:0] owner;
    } tbl_entry_t;

    // allocator control states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SEEK,
        ST_HREAD,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* design/handle_block_allocator_unit.sv */
`default_nettype none

// channel   | signals                                  | transaction
// ----------+------------------------------------------+-------------------------------
// s_axis    | tvalid tready tdata[47:0] tuser[1:0]     | one command (mode in tuser)
// m_axis    | tvalid tready tdata[55:0] tuser[1:0]     | one result (status in tuser)
//
// every command gives exactly one result; one command is worked on at a time
// reserve, free and device lookup walk the block table from block 1, one read
// a cycle on the table's single read port; handle lookup steps a running base
// one block a cycle; after reset a clearing pass writes every table entry,
// with s_axis_tready low; a stalled result waits in the output register and
// the next command is taken meanwhile, held only at its own finish

module handle_block_allocator_unit
    import hba_pkg::*;
#(
    parameter int BLOCK_SIZE = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // device_id, handle, request_count
    input  wire logic [1:0]  s_axis_tuser,  // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,  // range_start, range_end, owner_kind,
                                            // owner_device, zero pad
    output logic [1:0]       m_axis_tuser   // status
);

    localparam int NUM_BLOCKS = HANDLE_SPACE / BLOCK_SIZE;
    localparam int ADDR_W     = $clog2(NUM_BLOCKS);
    localparam int IDX_W      = $clog2(NUM_BLOCKS + 1);

    localparam logic [IDX_W-1:0]    NUM_IDX   = IDX_W'(NUM_BLOCKS);
    localparam logic [ADDR_W-1:0]   LAST_ADDR = ADDR_W'(NUM_BLOCKS - 1);
    localparam logic [BASE_W-1:0]   BS_STEP   = BASE_W'(BLOCK_SIZE);
    localparam logic [HANDLE_W-1:0] SPAN      = HANDLE_W'(BLOCK_SIZE - 1);

    // input fields
    logic [1:0]          in_mode;
    logic [HANDLE_W-1:0] in_device_id;
    logic [HANDLE_W-1:0] in_handle;
    logic [HANDLE_W-1:0] in_request_count;

    assign in_mode          = s_axis_tuser;
    assign in_device_id     = s_axis_tdata[15:0];
    assign in_handle        = s_axis_tdata[31:16];
    assign in_request_count = s_axis_tdata[47:32];

    // control state
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_idx_reg, clr_idx_next;
    logic                chk_vld_reg, chk_vld_next;
    logic                out_vld_reg, out_vld_next;

    // command and walk registers
    logic [1:0]          mode_reg, mode_next;
    logic [HANDLE_W-1:0] dev_reg, dev_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [BASE_W-1:0]   rd_base_reg, rd_base_next;
    logic [ADDR_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [BASE_W-1:0]   chk_base_reg, chk_base_next;

    // finished result waiting for the output register
    logic [1:0]          res_status_reg, res_status_next;
    logic [HANDLE_W-1:0] res_start_reg, res_start_next;
    logic [1:0]          res_kind_reg, res_kind_next;
    logic [HANDLE_W-1:0] res_dev_reg, res_dev_next;

    // output register
    logic [1:0]          out_status_reg, out_status_next;
    logic [HANDLE_W-1:0] out_start_reg, out_start_next;
    logic [HANDLE_W-1:0] out_end_reg, out_end_next;
    logic [1:0]          out_kind_reg, out_kind_next;
    logic [HANDLE_W-1:0] out_dev_reg, out_dev_next;

    // table ports
    logic                tbl_rd_en;
    logic [ADDR_W-1:0]   tbl_rd_addr;
    tbl_entry_t          tbl_rd_data;
    logic                tbl_wr_en;
    logic [ADDR_W-1:0]   tbl_wr_addr;
    tbl_entry_t          tbl_wr_data;

    logic                scan_hit;
    logic                seek_stop;
    logic                load_out;

    hba_table #(
        .ADDR_W (ADDR_W),
        .DEPTH  (NUM_BLOCKS)
    ) u_table (
        .clk     (clk),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data)
    );

    // reserve looks for an empty block, free and device lookup for an owned one
    always_comb
    begin
        if (mode_reg == MODE_RESERVE)
        begin
            scan_hit = !tbl_rd_data.in_use;
        end
        else
        begin
            scan_hit = tbl_rd_data.in_use && (tbl_rd_data.owner == dev_reg);
        end
    end

    // handle lies below the end of the block at the running base
    assign seek_stop = ({1'b0, handle_reg} < (rd_base_reg + BS_STEP));

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        chk_vld_next    = 1'b0;
        mode_next       = mode_reg;
        dev_next        = dev_reg;
        handle_next     = handle_reg;
        rd_idx_next     = rd_idx_reg;
        rd_base_next    = rd_base_reg;
        chk_idx_next    = chk_idx_reg;
        chk_base_next   = chk_base_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_kind_next   = res_kind_reg;
        res_dev_next    = res_dev_reg;
        s_axis_tready   = 1'b0;
        load_out        = 1'b0;
        tbl_rd_en       = 1'b0;
        tbl_rd_addr     = rd_idx_reg[ADDR_W-1:0];
        tbl_wr_en       = 1'b0;
        tbl_wr_addr     = chk_idx_reg;
        tbl_wr_data     = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                tbl_wr_en    = 1'b1;
                tbl_wr_addr  = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    mode_next       = in_mode;
                    dev_next        = in_device_id;
                    handle_next     = in_handle;
                    res_kind_next   = KIND_UNOWNED;
                    res_dev_next    = '0;
                    res_status_next = STATUS_OK;
                    res_start_next  = '0;
                    if (in_mode == MODE_LOOKUP_HANDLE)
                    begin
                        rd_idx_next  = '0;
                        rd_base_next = '0;
                        state_next   = ST_SEEK;
                    end
                    else if ((in_mode == MODE_RESERVE)
                             && ({1'b0, in_request_count} >= BS_STEP))
                    begin
                        res_status_next = STATUS_COUNT;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        // block 0 belongs to the system, walk starts at 1
                        rd_idx_next  = IDX_W'(1);
                        rd_base_next = BS_STEP;
                        state_next   = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue the next read while checking the previous one
                if (rd_idx_reg != NUM_IDX)
                begin
                    tbl_rd_en     = 1'b1;
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    rd_base_next  = rd_base_reg + BS_STEP;
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = rd_idx_reg[ADDR_W-1:0];
                    chk_base_next = rd_base_reg;
                end
                if (chk_vld_reg)
                begin
                    if (scan_hit)
                    begin
                        chk_vld_next   = 1'b0;
                        res_start_next = chk_base_reg[HANDLE_W-1:0];
                        state_next     = ST_DONE;
                        if (mode_reg == MODE_RESERVE)
                        begin
                            tbl_wr_en   = 1'b1;
                            tbl_wr_data = '{in_use: 1'b1, owner: dev_reg};
                        end
                        else if (mode_reg == MODE_FREE)
                        begin
                            tbl_wr_en = 1'b1;
                        end
                    end
                    else if (chk_idx_reg == LAST_ADDR)
                    begin
                        chk_vld_next    = 1'b0;
                        res_status_next = STATUS_NOT_FOUND;
                        state_next      = ST_DONE;
                    end
                end
            end

            ST_SEEK:
            begin
                if (seek_stop)
                begin
                    res_start_next = rd_base_reg[HANDLE_W-1:0];
                    if (rd_idx_reg == '0)
                    begin
                        res_kind_next = KIND_SYSTEM;
                        state_next    = ST_DONE;
                    end
                    else if (rd_idx_reg == NUM_IDX)
                    begin
                        // tail beyond the last whole block
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        tbl_rd_en  = 1'b1;
                        state_next = ST_HREAD;
                    end
                end
                else
                begin
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    rd_base_next = rd_base_reg + BS_STEP;
                end
            end

            ST_HREAD:
            begin
                if (tbl_rd_data.in_use)
                begin
                    res_kind_next = KIND_DEVICE;
                    res_dev_next  = tbl_rd_data.owner;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register, range start and end only on success
    always_comb
    begin
        out_vld_next    = out_vld_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        out_kind_next   = out_kind_reg;
        out_dev_next    = out_dev_reg;
        if (load_out)
        begin
            out_vld_next    = 1'b1;
            out_status_next = res_status_reg;
            out_kind_next   = res_kind_reg;
            out_dev_next    = res_dev_reg;
            if (res_status_reg == STATUS_OK)
            begin
                out_start_next = res_start_reg;
                out_end_next   = res_start_reg + SPAN;
            end
            else
            begin
                out_start_next = '0;
                out_end_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            chk_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            chk_vld_reg <= chk_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        dev_reg        <= dev_next;
        handle_reg     <= handle_next;
        rd_idx_reg     <= rd_idx_next;
        rd_base_reg    <= rd_base_next;
        chk_idx_reg    <= chk_idx_next;
        chk_base_reg   <= chk_base_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_kind_reg   <= res_kind_next;
        res_dev_reg    <= res_dev_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_end_reg    <= out_end_next;
        out_kind_reg   <= out_kind_next;
        out_dev_reg    <= out_dev_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {6'd0, out_dev_reg, out_kind_reg, out_end_reg, out_start_reg};

endmodule

`default_nettype wire

/* design/hba_table.sv */
`default_nettype none

module hba_table
    import hba_pkg::*;
#(
    parameter int ADDR_W = 8,
    parameter int DEPTH  = 256
)
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output tbl_entry_t             rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire tbl_entry_t        wr_data
);

    tbl_entry_t mem [DEPTH];
    tbl_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, enabled by rd_en
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* test/handle_block_allocator_unit_tb.sv */
`timescale 1ns / 100ps

module handle_block_allocator_unit_tb
    import hba_pkg::*;
;

    localparam int BLOCK_SIZE     = 256;
    localparam int NUM_BLOCKS     = HANDLE_SPACE / BLOCK_SIZE;
    // watchdog limit for the whole run of commands
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int TAIL_CYCLES    = NUM_BLOCKS + 40;
    // long receiver hold-off so the output register fills and s_axis stalls
    localparam int HOLD_AT_RESULT = 40;
    localparam int HOLD_CYCLES    = 3000;
    localparam int DIR_ROWS       = 25;

    // one command as seen on s_axis
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] device_id;
        logic [15:0] handle;
        logic [15:0] request_count;
    } command_t;

    // one answer as seen on m_axis
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] range_start;
        logic [15:0] range_end;
        logic [1:0]  owner_kind;
        logic [15:0] owner_device;
    } answer_t;

    // directed row: command, then an answer typed in where it is obvious
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] device_id;
        logic [15:0] handle;
        logic [15:0] request_count;
        bit          typed;
        logic [1:0]  status;
        logic [15:0] range_start;
        logic [15:0] range_end;
        logic [1:0]  owner_kind;
        logic [15:0] owner_device;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // device_id, handle, request_count
    logic [1:0]  s_axis_tuser;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // range_start, range_end, owner_kind, owner_device, pad
    logic [1:0]  m_axis_tuser;   // status

    // predictor's own copy of the block table
    bit          blk_used  [NUM_BLOCKS];
    logic [15:0] blk_owner [NUM_BLOCKS];

    answer_t     answers_due [$];
    row_t        dir_rows [DIR_ROWS];
    logic [15:0] device_pool [8];
    int          errors;
    int          cmds_sent;
    int          results_taken;
    int          cycles;
    bit          sender_calm;
    bit          receiver_calm;
    bit          hold_done;
    answer_t     got;
    answer_t     want;

    handle_block_allocator_unit #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // first-fit allocator: updates the table and returns the answer it owes
    function automatic answer_t predict_block_table(input command_t c);
        answer_t a;
        int      idx;
        int      base;
        a   = '0;
        idx = NUM_BLOCKS;
        case (c.mode)
            MODE_RESERVE:
            begin
                // size check wins over the free-block search
                if (c.request_count >= BLOCK_SIZE)
                    a.status = STATUS_COUNT;
                else
                begin
                    for (int b = 1; b < NUM_BLOCKS && idx == NUM_BLOCKS; b++)
                        if (!blk_used[b])
                            idx = b;
                    if (idx == NUM_BLOCKS)
                        a.status = STATUS_NOT_FOUND;
                    else
                    begin
                        blk_used[idx]  = 1'b1;
                        blk_owner[idx] = c.device_id;
                    end
                end
            end
            MODE_FREE, MODE_LOOKUP_DEVICE:
            begin
                // lowest owned block, block 0 never matches
                for (int b = 1; b < NUM_BLOCKS && idx == NUM_BLOCKS; b++)
                    if (blk_used[b] && blk_owner[b] == c.device_id)
                        idx = b;
                if (idx == NUM_BLOCKS)
                    a.status = STATUS_NOT_FOUND;
                else if (c.mode == MODE_FREE)
                    blk_used[idx] = 1'b0;
            end
            MODE_LOOKUP_HANDLE:
            begin
                // always ok; owner only read while the block is in use
                idx = c.handle / BLOCK_SIZE;
                if (idx == 0)
                    a.owner_kind = KIND_SYSTEM;
                else if (idx < NUM_BLOCKS && blk_used[idx])
                begin
                    a.owner_kind   = KIND_DEVICE;
                    a.owner_device = blk_owner[idx];
                end
            end
        endcase
        if (a.status == STATUS_OK)
        begin
            base          = idx * BLOCK_SIZE;
            a.range_start = 16'(base);
            a.range_end   = 16'(base + BLOCK_SIZE - 1);
        end
        return a;
    endfunction

    task automatic check_field(input string field, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_val, act_val);
        end
    endtask

    // one s_axis transaction; the answer is predicted at the accepting edge
    task automatic push_command(input command_t c, input bit typed, input answer_t typed_ans);
        answer_t predicted;
        int      gap;
        if (cmds_sent % 50 == 0)
            sender_calm = ($urandom_range(0, 3) == 0);
        gap = sender_calm ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {c.request_count, c.handle, c.device_id};
        s_axis_tuser  = c.mode;
        do @(posedge clk); while (!s_axis_tready);
        predicted = predict_block_table(c);
        answers_due.push_back(typed ? typed_ans : predicted);
        cmds_sent++;
    endtask

    // random commands with a mode mix given in percent; the rest is device lookup
    task automatic run_segment(input int n, input int pct_reserve, input int pct_free,
                               input int pct_handle);
        command_t c;
        int       pick;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < pct_reserve)
                c.mode = MODE_RESERVE;
            else if (pick < pct_reserve + pct_free)
                c.mode = MODE_FREE;
            else if (pick < pct_reserve + pct_free + pct_handle)
                c.mode = MODE_LOOKUP_HANDLE;
            else
                c.mode = MODE_LOOKUP_DEVICE;
            // mostly a small pool of devices so that frees and lookups hit
            c.device_id     = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                          : device_pool[$urandom_range(0, 7)];
            c.handle        = 16'($urandom);
            c.request_count = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(256, 65535))
                                                          : 16'($urandom_range(0, 255));
            push_command(c, 1'b0, '0);
        end
    endtask

    // stimulus and end of run
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_RESERVE;
        errors        = 0;
        cmds_sent     = 0;
        sender_calm   = 1'b0;
        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            blk_used[b]  = 1'b0;
            blk_owner[b] = '0;
        end
        device_pool[0] = 16'h0000;
        device_pool[1] = 16'hFFFF;
        for (int p = 2; p < 8; p++)
            device_pool[p] = 16'($urandom);

        // mode, device, handle, count, typed / status, start, end, kind, owner
        dir_rows = '{
            // system block and top of the handle space after reset
            '{MODE_LOOKUP_HANDLE, 'h0000, 'h0000, 'h0000, 1'b1,
              STATUS_OK, 'h0000, 'h00FF, KIND_SYSTEM, 'h0000},
            '{MODE_LOOKUP_HANDLE, 'hFFFF, 'hFFFF, 'hFFFF, 1'b1,
              STATUS_OK, 'hFF00, 'hFFFF, KIND_UNOWNED, 'h0000},
            // count too large, at the edge and at the top
            '{MODE_RESERVE, 'hFFFF, 'h0000, 'h0100, 1'b1,
              STATUS_COUNT, 'h0000, 'h0000, KIND_UNOWNED, 'h0000},
            '{MODE_RESERVE, 'h0000, 'hFFFF, 'hFFFF, 1'b1,
              STATUS_COUNT, 'h0000, 'h0000, KIND_UNOWNED, 'h0000},
            // device owns nothing, and block 0 never matches device 0
            '{MODE_FREE, 'h1234, 'h0000, 'h0000, 1'b1,
              STATUS_NOT_FOUND, 'h0000, 'h0000, KIND_UNOWNED, 'h0000},
            '{MODE_LOOKUP_DEVICE, 'h0000, 'h0000, 'h0000, 1'b1,
              STATUS_NOT_FOUND, 'h0000, 'h0000, KIND_UNOWNED, 'h0000},
            // first-fit reserves, device 0 twice
            '{MODE_RESERVE, 'h0000, 'h0000, 'h0000, 1'b1,
              STATUS_OK, 'h0100, 'h01FF, KIND_UNOWNED, 'h0000},
            '{MODE_RESERVE, 'hFFFF, 'h0000, 'h00FF, 1'b1,
              STATUS_OK, 'h0200, 'h02FF, KIND_UNOWNED, 'h0000},
            '{MODE_RESERVE, 'h0000, 'h0000, 'h0001, 1'b1,
              STATUS_OK, 'h0300, 'h03FF, KIND_UNOWNED, 'h0000},
            '{MODE_LOOKUP_HANDLE, 'h0000, 'h0100, 'h0000, 1'b1,
              STATUS_OK, 'h0100, 'h01FF, KIND_DEVICE, 'h0000},
            '{MODE_LOOKUP_HANDLE, 'h0000, 'h02FF, 'h0000, 1'b1,
              STATUS_OK, 'h0200, 'h02FF, KIND_DEVICE, 'hFFFF},
            // free and lookup act on the lowest owned block
            '{MODE_LOOKUP_DEVICE, 'h0000, 'h0000, 'h0000, 1'b1,
              STATUS_OK, 'h0100, 'h01FF, KIND_UNOWNED, 'h0000},
            '{MODE_FREE, 'h0000, 'h0000, 'h0000, 1'b1,
              STATUS_OK, 'h0100, 'h01FF, KIND_UNOWNED, 'h0000},
            '{MODE_LOOKUP_DEVICE, 'h0000, 'h0000, 'h0000, 1'b1,
              STATUS_OK, 'h0300, 'h03FF, KIND_UNOWNED, 'h0000},
            // freed block is reused first
            '{MODE_RESERVE, 'hA5A5, 'h0000, 'h0080, 1'b1,
              STATUS_OK, 'h0100, 'h01FF, KIND_UNOWNED, 'h0000},
            '{MODE_LOOKUP_HANDLE, 'h0000, 'h01AB, 'h0000, 1'b1,
              STATUS_OK, 'h0100, 'h01FF, KIND_DEVICE, 'hA5A5},
            '{MODE_LOOKUP_HANDLE, 'h0000, 'h0400, 'h0000, 1'b1,
              STATUS_OK, 'h0400, 'h04FF, KIND_UNOWNED, 'h0000},
            '{MODE_LOOKUP_HANDLE, 'h0000, 'h00FF, 'h0000, 1'b1,
              STATUS_OK, 'h0000, 'h00FF, KIND_SYSTEM, 'h0000},
            '{MODE_FREE, 'hFFFF, 'h0000, 'h0000, 1'b1,
              STATUS_OK, 'h0200, 'h02FF, KIND_UNOWNED, 'h0000},
            '{MODE_FREE, 'hFFFF, 'h0000, 'h0000, 1'b1,
              STATUS_NOT_FOUND, 'h0000, 'h0000, KIND_UNOWNED, 'h0000},
            '{MODE_LOOKUP_DEVICE, 'h5A5A, 'h0000, 'h0000, 1'b1,
              STATUS_NOT_FOUND, 'h0000, 'h0000, KIND_UNOWNED, 'h0000},
            '{MODE_RESERVE, 'h5A5A, 'h0000, 'h0100, 1'b1,
              STATUS_COUNT, 'h0000, 'h0000, KIND_UNOWNED, 'h0000},
            // left to the predictor
            '{MODE_LOOKUP_HANDLE, 'h0000, 'h8000, 'h0000, 1'b0,
              STATUS_OK, 'h0000, 'h0000, KIND_UNOWNED, 'h0000},
            '{MODE_LOOKUP_HANDLE, 'h0000, 'h0300, 'h0000, 1'b0,
              STATUS_OK, 'h0000, 'h0000, KIND_UNOWNED, 'h0000},
            '{MODE_FREE, 'h0000, 'h0000, 'h0000, 1'b0,
              STATUS_OK, 'h0000, 'h0000, KIND_UNOWNED, 'h0000}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part; the clearing pass is waited out by the handshake
        foreach (dir_rows[r])
            push_command({dir_rows[r].mode, dir_rows[r].device_id, dir_rows[r].handle,
                          dir_rows[r].request_count},
                         dir_rows[r].typed,
                         {dir_rows[r].status, dir_rows[r].range_start, dir_rows[r].range_end,
                          dir_rows[r].owner_kind, dir_rows[r].owner_device});

        // fill the table past full, drain it, then a mixed stretch
        run_segment(400, 85, 5, 5);
        run_segment(350, 10, 75, 8);
        run_segment(650, 30, 30, 20);

        @(negedge clk);
        s_axis_tvalid = 1'b0;

        while (answers_due.size() != 0)
            @(posedge clk);
        // a full table walk of quiet time to catch stray results
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stalls, calm stretches, and one long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        results_taken = 0;
        receiver_calm = 1'b0;
        hold_done     = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            int stall;
            @(negedge clk);
            if (results_taken % 50 == 0)
                receiver_calm = ($urandom_range(0, 3) == 0);
            if (results_taken == HOLD_AT_RESULT && !hold_done)
            begin
                hold_done     = 1'b1;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            stall = receiver_calm ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            results_taken++;
        end
    end

    // result check against the oldest outstanding answer
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                   m_axis_tdata[33:32], m_axis_tdata[49:34]};
            if (answers_due.size() == 0)
            begin
                errors++;
                $error("result transaction with no command outstanding");
            end
            else
            begin
                want = answers_due.pop_front();
                check_field("status",       want.status,       got.status);
                check_field("range_start",  want.range_start,  got.range_start);
                check_field("range_end",    want.range_end,    got.range_end);
                check_field("owner_kind",   want.owner_kind,   got.owner_kind);
                check_field("owner_device", want.owner_device, got.owner_device);
            end
        end
    end

    // watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
